[hw/rtl/mctd_pkg.sv]
// Package for the multi-channel touch debouncer.
// Holds the shared constants, operation and event codes, and the structs that
// pass between the lanes, the merge stage and the top level. No dependencies.
package mctd_pkg;

  localparam int unsigned ChannelsDef = 16;
  localparam int unsigned MaskBits    = 16;
  localparam int unsigned TimeW       = 32;
  localparam int unsigned DebW        = 16;
  localparam int unsigned CmdW        = 32;
  localparam int unsigned ChanIdxW    = 8;
  localparam int unsigned EvtChanW    = 4;

  typedef enum logic [2:0] {
    OP_POLL     = 3'd0,
    OP_ARM_DOWN = 3'd1,
    OP_ARM_UP   = 3'd2,
    OP_CLR_DOWN = 3'd3,
    OP_CLR_UP   = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    CFG_DEBOUNCE    = 2'd0,
    CFG_ACTIVE_MASK = 2'd1,
    CFG_EVENTS_EN   = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    EVT_DOWN     = 2'd0,
    EVT_UP       = 2'd1,
    EVT_EXP_DOWN = 2'd2,
    EVT_EXP_UP   = 2'd3
  } evt_kind_t;

  typedef struct packed {
    logic poll;
    logic arm_down;
    logic arm_up;
    logic clr_down;
    logic clr_up;
    logic events_en;
  } lane_ctl_t;

  typedef struct packed {
    logic              pend;
    evt_kind_t         kind;
    logic [CmdW-1:0]   cmd;
  } lane_evt_t;

endpackage

[hw/rtl/multi_channel_touch_debouncer_unit.sv]
// Touch debouncer with CHANNELS lanes (16 by default), of which only the first 16
// can be polled. On a poll every active lane updates its raw state, stamp and
// debounced state at once and latches its event. The merge stage then sends one
// event per cycle while the output is ready, in ascending channel order, through
// its single output register; the input is held off until every latched event
// has been moved into that register.
// Depends on mctd_pkg, mctd_lane and mctd_merge.
module multi_channel_touch_debouncer_unit #(
  parameter int unsigned CHANNELS = mctd_pkg::ChannelsDef
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [87:0] s_axis_tdata,  // now_ms, raw_touch_mask, channel_index, command_id
  input  logic [2:0]  s_axis_tuser,  // operation
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // event_channel, event_command, zero fill
  output logic [1:0]  m_axis_tuser,  // event_kind
  output logic        m_axis_tlast   // last_event
);
  import mctd_pkg::*;

  logic [DebW-1:0]      debounce_time;
  logic [MaskBits-1:0]  active_mask;
  logic                 events_en;

  logic [TimeW-1:0]     now_ms;
  logic [MaskBits-1:0]  raw_touch_mask;
  logic [ChanIdxW-1:0]  channel_index;
  logic [CmdW-1:0]      command_id;
  logic                 fire;
  lane_ctl_t            ctl;

  lane_evt_t            evt [CHANNELS];
  logic [CHANNELS-1:0]  grant;
  logic [CHANNELS-1:0]  pend;
  evt_kind_t            out_kind;
  logic [EvtChanW-1:0]  out_chan;
  logic [CmdW-1:0]      out_cmd;

  assign now_ms         = s_axis_tdata[31:0];
  assign raw_touch_mask = s_axis_tdata[47:32];
  assign channel_index  = s_axis_tdata[55:48];
  assign command_id     = s_axis_tdata[87:56];

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_time <= DebW'(50);
      active_mask   <= '0;
      events_en     <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_DEBOUNCE:    debounce_time <= cfg_wdata;
        CFG_ACTIVE_MASK: active_mask   <= cfg_wdata;
        CFG_EVENTS_EN:   events_en     <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < CHANNELS; i++) begin
      pend[i] = evt[i].pend;
    end
  end

  assign s_axis_tready = pend == '0;
  assign fire          = s_axis_tvalid && s_axis_tready;

  always_comb begin
    ctl           = '0;
    ctl.events_en = events_en;
    if (fire) begin
      unique case (op_t'(s_axis_tuser))
        OP_POLL:     ctl.poll     = 1'b1;
        OP_ARM_DOWN: ctl.arm_down = 1'b1;
        OP_ARM_UP:   ctl.arm_up   = 1'b1;
        OP_CLR_DOWN: ctl.clr_down = 1'b1;
        OP_CLR_UP:   ctl.clr_up   = 1'b1;
        default: ;
      endcase
    end
  end

  for (genvar g = 0; g < CHANNELS; g++) begin : g_lane
    logic active;
    logic raw_bit;
    logic sel;

    if (g < MaskBits) begin : g_polled
      assign active  = active_mask[g];
      assign raw_bit = raw_touch_mask[g];
    end else begin : g_unpolled
      assign active  = 1'b0;
      assign raw_bit = 1'b0;
    end

    assign sel = channel_index == ChanIdxW'(g);

    mctd_lane u_lane (
      .clk           (clk),
      .rst           (rst),
      .ctl           (ctl),
      .sel           (sel),
      .active        (active),
      .raw_bit       (raw_bit),
      .now_ms        (now_ms),
      .debounce_time (debounce_time),
      .command_id    (command_id),
      .grant         (grant[g]),
      .evt           (evt[g])
    );
  end

  mctd_merge #(
    .CHANNELS (CHANNELS)
  ) u_merge (
    .clk       (clk),
    .rst       (rst),
    .evt       (evt),
    .grant     (grant),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_kind  (out_kind),
    .out_chan  (out_chan),
    .out_cmd   (out_cmd),
    .out_last  (m_axis_tlast)
  );

  assign m_axis_tdata = {4'b0, out_cmd, out_chan};
  assign m_axis_tuser = out_kind;

  // At most one lane is released per cycle.
  a_grant_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0(grant))
    else $error("more than one lane granted");

  // Only a lane with a pending event may be released.
  a_grant_pending: assert property (@(posedge clk) disable iff (rst)
    (grant & ~pend) == '0)
    else $error("grant to a lane without a pending event");

  // With events disabled a poll leaves nothing to send.
  a_quiet_poll: assert property (@(posedge clk) disable iff (rst)
    ctl.poll && !events_en |=> pend == '0)
    else $error("event raised while events are disabled");

endmodule

[hw/rtl/mctd_lane.sv]
// One debounce lane: raw and debounced state, change stamp and the two
// one-shot expectations of a single channel, plus its pending event.
// Depends on mctd_pkg.
module mctd_lane (
  input  logic                        clk,
  input  logic                        rst,
  input  mctd_pkg::lane_ctl_t         ctl,
  input  logic                        sel,
  input  logic                        active,
  input  logic                        raw_bit,
  input  logic [mctd_pkg::TimeW-1:0]  now_ms,
  input  logic [mctd_pkg::DebW-1:0]   debounce_time,
  input  logic [mctd_pkg::CmdW-1:0]   command_id,
  input  logic                        grant,
  output mctd_pkg::lane_evt_t         evt
);
  import mctd_pkg::*;

  logic             raw_st;
  logic [TimeW-1:0] stamp;
  logic             deb_st;
  logic             down_armed;
  logic             up_armed;
  logic [CmdW-1:0]  down_cmd;
  logic [CmdW-1:0]  up_cmd;
  logic             pend;
  evt_kind_t        pend_kind;
  logic [CmdW-1:0]  pend_cmd;

  logic             changed;
  logic [TimeW-1:0] elapsed;
  logic             steady;
  logic             flip;
  logic             emit;

  assign changed = raw_bit != raw_st;
  assign elapsed = now_ms - stamp;
  assign steady  = changed ? (debounce_time == '0)
                           : (elapsed >= {{(TimeW-DebW){1'b0}}, debounce_time});
  assign flip    = ctl.poll && active && steady && (raw_bit != deb_st);
  assign emit    = flip && ctl.events_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      raw_st     <= 1'b0;
      stamp      <= '0;
      deb_st     <= 1'b0;
      down_armed <= 1'b0;
      up_armed   <= 1'b0;
      pend       <= 1'b0;
    end else begin
      if (ctl.poll && active) begin
        raw_st <= raw_bit;
        if (changed) begin
          stamp <= now_ms;
        end
      end
      if (flip) begin
        deb_st <= raw_bit;
      end
      if (emit) begin
        pend <= 1'b1;
        if (raw_bit) begin
          down_armed <= 1'b0;
        end else begin
          up_armed <= 1'b0;
        end
      end else if (grant) begin
        pend <= 1'b0;
      end
      if (sel) begin
        if (ctl.arm_down) begin
          down_armed <= 1'b1;
        end
        if (ctl.arm_up) begin
          up_armed <= 1'b1;
        end
        if (ctl.clr_down) begin
          down_armed <= 1'b0;
        end
        if (ctl.clr_up) begin
          up_armed <= 1'b0;
        end
      end
    end
  end

  // A command id is only ever read while its expectation is armed.
  always_ff @(posedge clk) begin
    if (sel && ctl.arm_down) begin
      down_cmd <= command_id;
    end
    if (sel && ctl.arm_up) begin
      up_cmd <= command_id;
    end
    if (emit) begin
      if (raw_bit) begin
        pend_kind <= down_armed ? EVT_EXP_DOWN : EVT_DOWN;
        pend_cmd  <= down_armed ? down_cmd : '0;
      end else begin
        pend_kind <= up_armed ? EVT_EXP_UP : EVT_UP;
        pend_cmd  <= up_armed ? up_cmd : '0;
      end
    end
  end

  assign evt.pend = pend;
  assign evt.kind = pend_kind;
  assign evt.cmd  = pend_cmd;

endmodule

[hw/rtl/mctd_merge.sv]
// Merge stage: picks the lowest channel with a pending event and moves it into
// the output register, marking the final event of a poll as last.
// Depends on mctd_pkg.
module mctd_merge #(
  parameter int unsigned CHANNELS = mctd_pkg::ChannelsDef
) (
  input  logic                           clk,
  input  logic                           rst,
  input  mctd_pkg::lane_evt_t            evt [CHANNELS],
  output logic [CHANNELS-1:0]            grant,
  output logic                           out_valid,
  input  logic                           out_ready,
  output mctd_pkg::evt_kind_t            out_kind,
  output logic [mctd_pkg::EvtChanW-1:0]  out_chan,
  output logic [mctd_pkg::CmdW-1:0]      out_cmd,
  output logic                           out_last
);
  import mctd_pkg::*;

  logic [CHANNELS-1:0] pend;
  logic [CHANNELS-1:0] lowest;
  logic                load;
  evt_kind_t           sel_kind;
  logic [EvtChanW-1:0] sel_chan;
  logic [CmdW-1:0]     sel_cmd;

  always_comb begin
    for (int i = 0; i < CHANNELS; i++) begin
      pend[i] = evt[i].pend;
    end
  end

  assign lowest = pend & (~pend + CHANNELS'(1));
  assign load   = !out_valid || out_ready;
  assign grant  = load ? lowest : '0;

  always_comb begin
    sel_kind = EVT_DOWN;
    sel_chan = '0;
    sel_cmd  = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      if (lowest[i]) begin
        sel_kind = evt[i].kind;
        sel_chan = EvtChanW'(i);
        sel_cmd  = evt[i].cmd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= |pend;
    end
  end

  always_ff @(posedge clk) begin
    if (load && |pend) begin
      out_kind <= sel_kind;
      out_chan <= sel_chan;
      out_cmd  <= sel_cmd;
      out_last <= (pend & ~lowest) == '0;
    end
  end

endmodule

[sim/touch_scoreboard_pkg.sv]
// Scoreboard for the multi-channel touch debouncer: a predictor of the debounce
// state and the armed expectations, and an in-order store of the events it awaits.
// Depends on mctd_pkg.
`timescale 1ns / 100ps
package touch_scoreboard_pkg;

  import mctd_pkg::*;

  typedef struct packed {
    evt_kind_t             kind;
    logic [EvtChanW-1:0]   chan;
    logic [CmdW-1:0]       cmd;
    logic                  last;
  } touch_event_t;

  class touch_scoreboard;

    logic [DebW-1:0]        hold_ms;
    logic [MaskBits-1:0]    active_mask;
    logic                   events_on;
    logic [ChannelsDef-1:0] raw_bits;
    logic [ChannelsDef-1:0] stable_bits;
    logic [ChannelsDef-1:0] down_armed;
    logic [ChannelsDef-1:0] up_armed;
    logic [TimeW-1:0]       stamp_ms [ChannelsDef];
    logic [CmdW-1:0]        down_cmd [ChannelsDef];
    logic [CmdW-1:0]        up_cmd [ChannelsDef];
    touch_event_t           awaited [$];
    int unsigned            errors;

    function new();
      hold_ms = 16'd50;
      active_mask = '0;
      events_on = 1'b1;
      raw_bits = '0;
      stable_bits = '0;
      down_armed = '0;
      up_armed = '0;
      for (int i = 0; i < ChannelsDef; i++) begin
        stamp_ms[i] = '0;
        down_cmd[i] = '0;
        up_cmd[i] = '0;
      end
      errors = 0;
    endfunction

    function void set_config(logic [DebW-1:0] deb, logic [MaskBits-1:0] mask, logic en);
      hold_ms = deb;
      active_mask = mask;
      events_on = en;
    endfunction

    function int unsigned pending();
      return awaited.size();
    endfunction

    function void note_input(logic [2:0] op, logic [TimeW-1:0] now, logic [MaskBits-1:0] raw,
                             logic [ChanIdxW-1:0] ch, logic [CmdW-1:0] cmd);
      touch_event_t     ev;
      logic [TimeW-1:0] elapsed;
      int unsigned      found;
      found = 0;
      case (op)
        OP_ARM_DOWN: if (ch < ChannelsDef) begin
          down_armed[ch] = 1'b1;
          down_cmd[ch] = cmd;
        end
        OP_ARM_UP: if (ch < ChannelsDef) begin
          up_armed[ch] = 1'b1;
          up_cmd[ch] = cmd;
        end
        OP_CLR_DOWN: if (ch < ChannelsDef) begin
          down_armed[ch] = 1'b0;
          down_cmd[ch] = '0;
        end
        OP_CLR_UP: if (ch < ChannelsDef) begin
          up_armed[ch] = 1'b0;
          up_cmd[ch] = '0;
        end
        OP_POLL: begin
          for (int i = 0; i < ChannelsDef && i < MaskBits; i++) begin
            if (active_mask[i] && raw[i] != raw_bits[i]) begin
              raw_bits[i] = raw[i];
              stamp_ms[i] = now;
            end
          end
          for (int i = 0; i < ChannelsDef && i < MaskBits; i++) begin
            if (!active_mask[i]) continue;
            elapsed = now - stamp_ms[i];
            if (elapsed < hold_ms || raw_bits[i] == stable_bits[i]) continue;
            stable_bits[i] = raw_bits[i];
            if (!events_on) continue;
            ev.chan = EvtChanW'(i);
            ev.cmd = '0;
            ev.last = 1'b0;
            if (stable_bits[i]) begin
              ev.kind = EVT_DOWN;
              if (down_armed[i]) begin
                ev.kind = EVT_EXP_DOWN;
                ev.cmd = down_cmd[i];
                down_armed[i] = 1'b0;
                down_cmd[i] = '0;
              end
            end else begin
              ev.kind = EVT_UP;
              if (up_armed[i]) begin
                ev.kind = EVT_EXP_UP;
                ev.cmd = up_cmd[i];
                up_armed[i] = 1'b0;
                up_cmd[i] = '0;
              end
            end
            awaited.push_back(ev);
            found++;
          end
          if (found > 0) begin
            ev = awaited.pop_back();
            ev.last = 1'b1;
            awaited.push_back(ev);
          end
        end
        default: ;
      endcase
    endfunction

    task report(string what);
      $display("mismatch at %0t: %s", $time, what);
      errors++;
    endtask

    task check_result(logic [1:0] kind, logic [39:0] data, logic last);
      touch_event_t want;
      if (awaited.size() == 0) begin
        report($sformatf("event with none awaited: kind %0d channel %0d", kind, data[3:0]));
        return;
      end
      want = awaited.pop_front();
      if (kind !== want.kind)
        report($sformatf("kind %0d, awaited %0d", kind, want.kind));
      if (data[3:0] !== want.chan)
        report($sformatf("channel %0d, awaited %0d", data[3:0], want.chan));
      if (data[35:4] !== want.cmd)
        report($sformatf("command %h, awaited %h", data[35:4], want.cmd));
      if (data[39:36] !== 4'd0)
        report($sformatf("fill bits %b are not zero", data[39:36]));
      if (last !== want.last)
        report($sformatf("last flag %b, awaited %b", last, want.last));
    endtask

  endclass

endpackage

[sim/tb_top.sv]
// Top level of the testbench for multi_channel_touch_debouncer_unit: drives
// directed and random polls, arms and clears with random idling on both sides.
// Depends on mctd_pkg, touch_scoreboard_pkg and the debouncer RTL.
`timescale 1ns / 100ps
module tb_top;

  import mctd_pkg::*;
  import touch_scoreboard_pkg::*;

  localparam int unsigned CycleLimit = 500000;
  localparam logic [2:0] OP_SPARE_LO = 3'd5;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = CFG_DEBOUNCE;
  logic [15:0] cfg_wdata = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [87:0] s_axis_tdata = '0;  // now_ms, raw_touch_mask, channel_index, command_id
  logic [2:0]  s_axis_tuser = OP_POLL;  // operation
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;  // event_channel, event_command, zero fill
  logic [1:0]  m_axis_tuser;  // event_kind
  logic        m_axis_tlast;  // last_event

  touch_scoreboard sb = new();
  bit              tx_calm = 1'b0;
  int unsigned     tx_gap = 0;
  int unsigned     cycles = 0;
  logic [31:0]     clock_ms = '0;
  logic [15:0]     raw_now = '0;
  logic [15:0]     deb;

  multi_channel_touch_debouncer_unit #(
    .CHANNELS(ChannelsDef)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic int unsigned draw_wait(input bit calm);
    return calm ? 0 : $urandom_range(0, 18);
  endfunction

  task automatic write_settings(input logic [15:0] debounce, input logic [15:0] mask,
                                input logic en);
    cfg_we <= 1'b1;
    cfg_index <= CFG_DEBOUNCE;
    cfg_wdata <= debounce;
    @(posedge clk);
    cfg_index <= CFG_ACTIVE_MASK;
    cfg_wdata <= mask;
    @(posedge clk);
    cfg_index <= CFG_EVENTS_EN;
    cfg_wdata <= {15'd0, en};
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_config(debounce, mask, en);
  endtask

  task automatic send_item(input logic [2:0] op, input logic [31:0] now,
                           input logic [15:0] raw, input logic [7:0] ch,
                           input logic [31:0] cmd);
    repeat (tx_gap) @(posedge clk);
    if (!s_axis_tvalid) s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {cmd, ch, raw, now};
    s_axis_tuser <= op;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_input(op, now, raw, ch, cmd);
    if ($urandom_range(0, 15) == 0) tx_calm = !tx_calm;
    tx_gap = draw_wait(tx_calm);
    if (tx_gap > 0) s_axis_tvalid <= 1'b0;
  endtask

  // Holds the sender off until every awaited event has come out and the
  // output stage has had time to empty.
  task automatic settle();
    if (tx_gap == 0) s_axis_tvalid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (24) @(posedge clk);
  endtask

  task automatic random_phase(input int unsigned count, input logic [15:0] debounce);
    int unsigned pick;
    logic [31:0] step;
    logic [7:0]  ch;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        if ($urandom_range(0, 9) == 0) step = debounce + $urandom_range(0, 3);
        else step = $urandom_range(0, debounce / 3 + 2);
        clock_ms = clock_ms + step;
        raw_now = raw_now ^ 16'($urandom & $urandom & $urandom);
        send_item(OP_POLL, clock_ms, raw_now, 8'($urandom), $urandom);
      end else if (pick < 70) begin
        send_item(OP_POLL, $urandom, 16'($urandom), 8'($urandom), $urandom);
      end else if (pick < 93) begin
        ch = ($urandom_range(0, 9) == 0) ? 8'($urandom)
                                         : 8'($urandom_range(0, ChannelsDef - 1));
        send_item(3'($urandom_range(OP_ARM_DOWN, OP_CLR_UP)), $urandom, 16'($urandom), ch,
                  $urandom);
      end else begin
        send_item(3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI)), $urandom, 16'($urandom),
                  8'($urandom), $urandom);
      end
    end
  endtask

  initial begin : event_sink
    bit          calm;
    int unsigned stall;
    calm = 1'b0;
    wait (!rst);
    forever begin
      if ($urandom_range(0, 15) == 0) calm = !calm;
      stall = draw_wait(calm);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
      sb.check_result(m_axis_tuser, m_axis_tdata, m_axis_tlast);
    end
  end

  initial begin : stimulus
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Zero debounce time, all channels, arming at the edges of the index range.
    write_settings(16'd0, 16'hFFFF, 1'b1);
    send_item(OP_ARM_DOWN, 32'd0, 16'h0000, 8'd0, 32'hFFFF_FFFF);
    send_item(OP_ARM_UP, 32'hFFFF_FFFF, 16'hFFFF, 8'd15, 32'hA5A5_5A5A);
    send_item(OP_ARM_DOWN, $urandom, 16'($urandom), 8'hFF, $urandom);
    send_item(OP_ARM_UP, $urandom, 16'($urandom), 8'(ChannelsDef), $urandom);
    send_item(OP_SPARE_LO, 32'hFFFF_FFFF, 16'hFFFF, 8'd2, 32'hFFFF_FFFF);
    send_item(OP_SPARE_LO + 3'd1, $urandom, 16'($urandom), 8'd4, $urandom);
    send_item(OP_SPARE_HI, $urandom, 16'($urandom), 8'd5, $urandom);
    send_item(OP_ARM_DOWN, $urandom, 16'($urandom), 8'd7, 32'h0000_1234);
    send_item(OP_CLR_DOWN, $urandom, 16'($urandom), 8'd7, $urandom);
    send_item(OP_ARM_UP, $urandom, 16'($urandom), 8'd3, 32'h0BAD_F00D);
    send_item(OP_CLR_UP, $urandom, 16'($urandom), 8'd3, $urandom);
    send_item(OP_CLR_DOWN, $urandom, 16'($urandom), 8'd200, $urandom);
    send_item(OP_POLL, 32'd0, 16'hFFFF, 8'd0, 32'd0);
    send_item(OP_POLL, 32'd0, 16'hFFFF, 8'd0, 32'd0);
    send_item(OP_POLL, 32'hFFFF_FFFF, 16'h0000, 8'd0, 32'd0);
    send_item(OP_POLL, 32'hFFFF_FFFF, 16'h5555, 8'd0, 32'd0);
    settle();

    // Longest debounce time with events switched off; the arm must survive.
    write_settings(16'hFFFF, 16'hFFFF, 1'b0);
    send_item(OP_ARM_DOWN, $urandom, 16'($urandom), 8'd1, 32'hC0DE_0001);
    send_item(OP_POLL, 32'd10, 16'hAAAA, 8'd0, 32'd0);
    send_item(OP_POLL, 32'd65544, 16'hAAAA, 8'd0, 32'd0);
    send_item(OP_POLL, 32'd65545, 16'hAAAA, 8'd0, 32'd0);
    settle();

    write_settings(16'd50, 16'h0000, 1'b1);
    send_item(OP_POLL, $urandom, 16'($urandom), 8'($urandom), $urandom);
    settle();

    deb = 16'($urandom_range(1, 20));
    write_settings(deb, 16'hFFFF, 1'b1);
    clock_ms = 32'hFFFF_FFE0;
    raw_now = 16'hAAAA;
    random_phase(32, deb);
    settle();

    write_settings(16'd0, 16'($urandom), 1'b1);
    random_phase(25, 16'd0);
    settle();

    deb = 16'($urandom_range(2, 12));
    write_settings(deb, 16'($urandom), 1'b0);
    random_phase(20, deb);
    settle();

    deb = 16'($urandom_range(2, 12));
    write_settings(deb, 16'hFFFF, 1'b1);
    random_phase(32, deb);
    settle();

    write_settings(16'hFFFF, 16'hFFFF, 1'b1);
    random_phase(14, 16'hFFFF);
    settle();

    if (sb.errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

[files.f]
hw/rtl/mctd_pkg.sv
hw/rtl/mctd_lane.sv
hw/rtl/mctd_merge.sv
hw/rtl/multi_channel_touch_debouncer_unit.sv
sim/touch_scoreboard_pkg.sv
sim/tb_top.sv
